[sv/pbc_pkg.sv]
// Shared types, mode codes and the rounded channel product for the pixel blend combiner.
`default_nettype none

package pbc_pkg;

   // Blend mode codes held in the mode register.
   localparam logic [3:0] MODE_ADD       = 4'd0;
   localparam logic [3:0] MODE_SUB       = 4'd1;
   localparam logic [3:0] MODE_MUL       = 4'd2;
   localparam logic [3:0] MODE_MIN       = 4'd3;
   localparam logic [3:0] MODE_MAX       = 4'd4;
   localparam logic [3:0] MODE_SETALPHA  = 4'd5;
   localparam logic [3:0] MODE_PREALPHA  = 4'd6;
   localparam logic [3:0] MODE_OVER      = 4'd7;
   localparam logic [3:0] MODE_MULTIPLY  = 4'd8;
   localparam logic [3:0] MODE_SCREEN    = 4'd9;
   localparam logic [3:0] MODE_DARKLIGHT = 4'd10;

   localparam int LaneCount = 4;
   localparam int AlphaLane = 3;

   localparam logic [32:0] RoundBias = 33'h0_0000_8000;

   // One request: base pixel, top pixel and the darken/lighten select.
   typedef struct packed {
      logic [15:0] base_red;
      logic [15:0] base_green;
      logic [15:0] base_blue;
      logic [15:0] base_alpha;
      logic [15:0] top_red;
      logic [15:0] top_green;
      logic [15:0] top_blue;
      logic [15:0] top_alpha;
      logic        lighten_select;
   } pixel_req_type;

   // One result pixel.
   typedef struct packed {
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [15:0] out_alpha;
   } pixel_rsp_type;

   // Load enables for the two lane pipeline stages.
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_enable_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      logic [15:0] base;
      logic [15:0] top;
      logic [15:0] m0;
      logic [15:0] m1;
      logic [15:0] m2;
   } lane_out_type;

   // Rounded x*y/65535 from the raw 32-bit product.
   function automatic logic [15:0] round_product(input logic [31:0] prod);
      logic [32:0] biased;
      logic [33:0] folded;
      biased = {1'b0, prod} + RoundBias;
      folded = {1'b0, biased} + {17'd0, biased[32:16]};
      return folded[31:16];
   endfunction

endpackage

`default_nettype wire

[sv/pbc_lane.sv]
// One channel lane: selects product operands by mode, multiplies, then rounds.
`default_nettype none

module pbc_lane (
   input  wire logic                      clock,
   input  wire pbc_pkg::stage_enable_type enable,
   input  wire logic                      is_alpha,
   input  wire logic [3:0]                blend_mode,
   input  wire logic [15:0]               base_chan,
   input  wire logic [15:0]               top_chan,
   input  wire logic [15:0]               base_alpha,
   input  wire logic [15:0]               top_alpha,
   input  wire logic [15:0]               top_red,
   output pbc_pkg::lane_out_type          lane_out
);

   logic [15:0] x0, y0, x1, y1, x2, y2;
   logic [31:0] p0_ff, p1_ff, p2_ff;
   logic [15:0] base_a_ff, top_a_ff;
   pbc_pkg::lane_out_type lane_ff, lane_in;

   // Operand pairs for up to three products; 65535 - v is the bitwise inverse.
   always_comb begin
      x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
      case (blend_mode)
         pbc_pkg::MODE_MUL: begin
            x0 = base_chan; y0 = top_chan;
         end
         pbc_pkg::MODE_PREALPHA: begin
            x0 = base_chan; y0 = top_red;
         end
         pbc_pkg::MODE_OVER: begin
            if (is_alpha) begin
               x0 = top_alpha; y0 = ~base_alpha;
            end else begin
               x0 = ~top_alpha; y0 = base_chan;
            end
         end
         pbc_pkg::MODE_MULTIPLY: begin
            if (is_alpha) begin
               x0 = top_alpha; y0 = ~base_alpha;
            end else begin
               x0 = ~top_alpha;  y0 = base_chan;
               x1 = ~base_alpha; y1 = top_chan;
               x2 = top_chan;    y2 = base_chan;
            end
         end
         pbc_pkg::MODE_SCREEN: begin
            x0 = top_chan; y0 = ~base_chan;
         end
         pbc_pkg::MODE_DARKLIGHT: begin
            if (is_alpha) begin
               x0 = top_alpha; y0 = ~base_alpha;
            end else begin
               x0 = top_chan;  y0 = base_alpha;
               x1 = base_chan; y1 = top_alpha;
            end
         end
         default: begin
         end
      endcase
   end

   // Stage A: raw products and the channel operands.
   always_ff @(posedge clock) begin
      if (enable.load_a) begin
         p0_ff     <= 32'(x0) * 32'(y0);
         p1_ff     <= 32'(x1) * 32'(y1);
         p2_ff     <= 32'(x2) * 32'(y2);
         base_a_ff <= base_chan;
         top_a_ff  <= top_chan;
      end
   end

   // Stage B: rounding of each product.
   always_comb begin
      lane_in.base = base_a_ff;
      lane_in.top  = top_a_ff;
      lane_in.m0   = pbc_pkg::round_product(p0_ff);
      lane_in.m1   = pbc_pkg::round_product(p1_ff);
      lane_in.m2   = pbc_pkg::round_product(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (enable.load_b) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

[sv/pbc_merge.sv]
// Merging stage: combines the lane products into the final pixel and registers it.
`default_nettype none

module pbc_merge (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [3:0]            blend_mode,
   input  wire logic                  lighten_select,
   input  wire logic [15:0]           top_red,
   input  wire logic [15:0]           top_green,
   input  wire pbc_pkg::lane_out_type lanes [pbc_pkg::LaneCount],
   output pbc_pkg::pixel_rsp_type     rsp_data
);

   logic [15:0] result [pbc_pkg::LaneCount];
   pbc_pkg::pixel_rsp_type rsp_ff, rsp_in;

   // Per-channel combine; sums that are not clamped wrap to 16 bits.
   always_comb begin
      for (int i = 0; i < pbc_pkg::LaneCount; i++) begin
         logic [16:0] sum;
         logic [15:0] b, t, m0, m1, m2, pick;
         logic        alpha;
         b     = lanes[i].base;
         t     = lanes[i].top;
         m0    = lanes[i].m0;
         m1    = lanes[i].m1;
         m2    = lanes[i].m2;
         alpha = (i == pbc_pkg::AlphaLane);
         sum   = {1'b0, b} + {1'b0, t};
         if (lighten_select) begin
            pick = (m0 < m1) ? m0 : m1;
         end else begin
            pick = (m0 > m1) ? m0 : m1;
         end
         case (blend_mode)
            pbc_pkg::MODE_ADD: begin
               result[i] = sum[16] ? 16'hFFFF : sum[15:0];
            end
            pbc_pkg::MODE_SUB: begin
               result[i] = (b > t) ? (b - t) : 16'd0;
            end
            pbc_pkg::MODE_MUL: begin
               result[i] = m0;
            end
            pbc_pkg::MODE_MIN: begin
               result[i] = (b < t) ? b : t;
            end
            pbc_pkg::MODE_MAX: begin
               result[i] = (b > t) ? b : t;
            end
            pbc_pkg::MODE_SETALPHA: begin
               result[i] = alpha ? top_red : b;
            end
            pbc_pkg::MODE_PREALPHA: begin
               result[i] = alpha ? top_green : m0;
            end
            pbc_pkg::MODE_OVER: begin
               result[i] = alpha ? (b + m0) : (m0 + t);
            end
            pbc_pkg::MODE_MULTIPLY: begin
               result[i] = alpha ? (b + m0) : (m0 + m1 + m2);
            end
            pbc_pkg::MODE_SCREEN: begin
               result[i] = b + m0;
            end
            pbc_pkg::MODE_DARKLIGHT: begin
               result[i] = alpha ? (b + m0) : (sum[15:0] - pick);
            end
            default: begin
               result[i] = b;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.out_red   = result[0];
      rsp_in.out_green = result[1];
      rsp_in.out_blue  = result[2];
      rsp_in.out_alpha = result[3];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[sv/pixel_blend_combiner.sv]
// Top level of the pixel blend combiner: mode register, lanes, merge and pipeline control.
//
// Usage: a request carries a base and a top RGBA pixel (16 bits a channel) and the
// darken/lighten select; it is taken at a rising edge where req_valid is high and
// req_stall is low. Each request yields one result pixel on rsp_data, offered with
// rsp_valid and taken at an edge where rsp_stall is low.
// The blend mode is written through csr_wr_en/csr_wr_data while no request is in flight.
// From request to result there are three registers: the multiply stage, the rounding stage
// and the merging output register. Four channel lanes work side by side, so one
// request is taken every cycle while req_stall is low, through the three-stage pipeline.
// When the receiver stalls, the pipeline first fills its empty stages and then raises
// req_stall; a held result stays unchanged on rsp_data until it is taken.
// Synchronous reset empties the pipeline and sets the mode to saturating add.
`default_nettype none

module pixel_blend_combiner (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pbc_pkg::pixel_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pbc_pkg::pixel_rsp_type      rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [3:0]             csr_wr_data
);

   logic [3:0] blend_mode_ff;
   logic       valid_a_ff, valid_b_ff, valid_c_ff;
   logic       load_c;
   pbc_pkg::stage_enable_type enable;
   logic       lighten_a_ff, lighten_b_ff;
   logic [15:0] top_red_a_ff, top_red_b_ff, top_green_a_ff, top_green_b_ff;
   logic [15:0] base_chans [pbc_pkg::LaneCount];
   logic [15:0] top_chans  [pbc_pkg::LaneCount];
   pbc_pkg::lane_out_type lanes [pbc_pkg::LaneCount];

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= pbc_pkg::MODE_ADD;
      end else if (csr_wr_en) begin
         blend_mode_ff <= csr_wr_data;
      end
   end

   // A stage loads when it is empty or its successor loads.
   assign load_c        = !valid_c_ff || !rsp_stall;
   assign enable.load_b = !valid_b_ff || load_c;
   assign enable.load_a = !valid_a_ff || enable.load_b;
   assign req_stall     = !enable.load_a;
   assign rsp_valid     = valid_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (enable.load_a) valid_a_ff <= req_valid;
         if (enable.load_b) valid_b_ff <= valid_a_ff;
         if (load_c)        valid_c_ff <= valid_b_ff;
      end
   end

   // Side fields that only the merging stage needs travel alongside the lanes.
   always_ff @(posedge clock) begin
      if (enable.load_a) begin
         lighten_a_ff   <= req_data.lighten_select;
         top_red_a_ff   <= req_data.top_red;
         top_green_a_ff <= req_data.top_green;
      end
      if (enable.load_b) begin
         lighten_b_ff   <= lighten_a_ff;
         top_red_b_ff   <= top_red_a_ff;
         top_green_b_ff <= top_green_a_ff;
      end
   end

   // Channel operands for each lane.
   assign base_chans[0] = req_data.base_red;
   assign base_chans[1] = req_data.base_green;
   assign base_chans[2] = req_data.base_blue;
   assign base_chans[3] = req_data.base_alpha;
   assign top_chans[0]  = req_data.top_red;
   assign top_chans[1]  = req_data.top_green;
   assign top_chans[2]  = req_data.top_blue;
   assign top_chans[3]  = req_data.top_alpha;

   for (genvar g = 0; g < pbc_pkg::LaneCount; g++) begin : g_lane
      pbc_lane u_lane (
         .clock      (clock),
         .enable     (enable),
         .is_alpha   (g == pbc_pkg::AlphaLane),
         .blend_mode (blend_mode_ff),
         .base_chan  (base_chans[g]),
         .top_chan   (top_chans[g]),
         .base_alpha (req_data.base_alpha),
         .top_alpha  (req_data.top_alpha),
         .top_red    (req_data.top_red),
         .lane_out   (lanes[g])
      );
   end

   pbc_merge u_merge (
      .clock          (clock),
      .load           (load_c),
      .blend_mode     (blend_mode_ff),
      .lighten_select (lighten_b_ff),
      .top_red        (top_red_b_ff),
      .top_green      (top_green_b_ff),
      .lanes          (lanes),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the pixel blend combiner: directed and random pixel pairs.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of encodings of the 4-bit mode register, used ones and unused ones alike.
   localparam int ModeCodes = 16;
   localparam logic [15:0] ChannelMax = 16'hFFFF;
   localparam logic [15:0] ChannelHalf = 16'h8000;
   localparam int PairsPerMode = 24;
   localparam int DrainCycles = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pbc_pkg::pixel_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pbc_pkg::pixel_rsp_type rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [3:0]             csr_wr_data = pbc_pkg::MODE_ADD;

   pbc_pkg::pixel_req_type pixel_pairs_q[$];
   pbc_pkg::pixel_rsp_type blended_q[$];
   logic [3:0]             mode_copy = pbc_pkg::MODE_ADD;
   logic                   req_taken = 1'b0;
   int                     pairs_issued = 0;
   int                     pairs_accepted = 0;
   int                     mismatch_count = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;

   pixel_blend_combiner uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Rounded x*y/65535: bias by half a step, then fold the high half back in.
   function automatic logic [15:0] rounded_scale(input logic [15:0] x, input logic [15:0] y);
      logic [33:0] xw;
      logic [33:0] yw;
      logic [33:0] acc;
      xw = x;
      yw = y;
      acc = xw * yw + 34'h8000;
      acc = (acc + (acc >> 16)) >> 16;
      return acc[15:0];
   endfunction

   // Expected combined pixel for one request under the given mode.
   function automatic pbc_pkg::pixel_rsp_type blend_pixel(input pbc_pkg::pixel_req_type px,
                                                          input logic [3:0] mode);
      logic [15:0]            b[4];
      logic [15:0]            tp[4];
      logic [15:0]            r[4];
      logic [16:0]            sum;
      logic [15:0]            p;
      logic [15:0]            q;
      logic [15:0]            s;
      logic [15:0]            top_cover;
      pbc_pkg::pixel_rsp_type res;
      b[0] = px.base_red;
      b[1] = px.base_green;
      b[2] = px.base_blue;
      b[3] = px.base_alpha;
      tp[0] = px.top_red;
      tp[1] = px.top_green;
      tp[2] = px.top_blue;
      tp[3] = px.top_alpha;
      for (int k = 0; k < 4; k++) r[k] = b[k];
      // Alpha of the compositing modes: base alpha plus top alpha over what is left.
      top_cover = b[3] + rounded_scale(tp[3], ChannelMax - b[3]);
      case (mode)
         pbc_pkg::MODE_ADD: begin
            for (int k = 0; k < 4; k++) begin
               sum = {1'b0, b[k]} + {1'b0, tp[k]};
               r[k] = sum[16] ? ChannelMax : sum[15:0];
            end
         end
         pbc_pkg::MODE_SUB: begin
            for (int k = 0; k < 4; k++) r[k] = (b[k] > tp[k]) ? b[k] - tp[k] : 16'd0;
         end
         pbc_pkg::MODE_MUL: begin
            for (int k = 0; k < 4; k++) r[k] = rounded_scale(b[k], tp[k]);
         end
         pbc_pkg::MODE_MIN: begin
            for (int k = 0; k < 4; k++) r[k] = (b[k] < tp[k]) ? b[k] : tp[k];
         end
         pbc_pkg::MODE_MAX: begin
            for (int k = 0; k < 4; k++) r[k] = (b[k] > tp[k]) ? b[k] : tp[k];
         end
         pbc_pkg::MODE_SETALPHA: begin
            r[3] = tp[0];
         end
         pbc_pkg::MODE_PREALPHA: begin
            for (int k = 0; k < 3; k++) r[k] = rounded_scale(b[k], tp[0]);
            r[3] = tp[1];
         end
         pbc_pkg::MODE_OVER: begin
            for (int k = 0; k < 3; k++) r[k] = rounded_scale(ChannelMax - tp[3], b[k]) + tp[k];
            r[3] = top_cover;
         end
         pbc_pkg::MODE_MULTIPLY: begin
            for (int k = 0; k < 3; k++) begin
               r[k] = rounded_scale(ChannelMax - tp[3], b[k])
                    + rounded_scale(ChannelMax - b[3], tp[k])
                    + rounded_scale(tp[k], b[k]);
            end
            r[3] = top_cover;
         end
         pbc_pkg::MODE_SCREEN: begin
            for (int k = 0; k < 4; k++) r[k] = b[k] + rounded_scale(tp[k], ChannelMax - b[k]);
         end
         pbc_pkg::MODE_DARKLIGHT: begin
            for (int k = 0; k < 3; k++) begin
               p = rounded_scale(tp[k], b[3]);
               q = rounded_scale(b[k], tp[3]);
               if (px.lighten_select) begin
                  s = (p < q) ? p : q;
               end else begin
                  s = (p > q) ? p : q;
               end
               // The sum wraps modulo 65536, also when the difference goes negative.
               r[k] = b[k] + tp[k] - s;
            end
            r[3] = top_cover;
         end
         default: begin
         end
      endcase
      res.out_red = r[0];
      res.out_green = r[1];
      res.out_blue = r[2];
      res.out_alpha = r[3];
      return res;
   endfunction

   function automatic pbc_pkg::pixel_req_type make_pixel(input logic [63:0] base,
                                                          input logic [63:0] top,
                                                          input logic lighten);
      pbc_pkg::pixel_req_type px;
      {px.base_red, px.base_green, px.base_blue, px.base_alpha} = base;
      {px.top_red, px.top_green, px.top_blue, px.top_alpha} = top;
      px.lighten_select = lighten;
      return px;
   endfunction

   // Random channel value, weighted toward the extremes and the midpoint.
   function automatic logic [15:0] pick_channel();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return ChannelMax;
         2: return ChannelHalf;
         3: return ChannelHalf - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_channel(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   task automatic queue_pixel(input pbc_pkg::pixel_req_type px);
      pixel_pairs_q.push_back(px);
      pairs_issued++;
   endtask

   // Wait until every request has been taken and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pairs_accepted != pairs_issued || blended_q.size() != 0);
   endtask

   task automatic write_mode(input logic [3:0] mode);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Request driver: holds a stalled request, otherwise offers the next pixel pair or idles.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pixel_pairs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_data <= pixel_pairs_q.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: tracks the mode, predicts accepted requests and checks results in order.
   always @(posedge clock) begin
      pbc_pkg::pixel_rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (reset) begin
         mode_copy <= pbc_pkg::MODE_ADD;
      end else begin
         if (csr_wr_en) mode_copy <= csr_wr_data;
         if (req_valid && !req_stall) begin
            blended_q.push_back(blend_pixel(req_data, mode_copy));
            pairs_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (blended_q.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = blended_q.pop_front();
               check_channel("out_red", rsp_data.out_red, want.out_red);
               check_channel("out_green", rsp_data.out_green, want.out_green);
               check_channel("out_blue", rsp_data.out_blue, want.out_blue);
               check_channel("out_alpha", rsp_data.out_alpha, want.out_alpha);
            end
         end
      end
   end

   // Stimulus: directed pixels under every mode, then random phases with idling.
   initial begin
      int phase_send[4];
      int phase_stall[4];
      logic [63:0] base;
      logic [63:0] top;
      phase_send = '{0, 77, 0, 26};
      phase_stall = '{0, 0, 77, 26};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: saturation and full-scale products, then mixed extremes that make
      // sums wrap and differences fall below zero. Unused modes pass the base pixel.
      for (int m = pbc_pkg::MODE_ADD; m <= pbc_pkg::MODE_DARKLIGHT; m++) begin
         write_mode(4'(m));
         queue_pixel(make_pixel({4{ChannelMax}}, {4{ChannelMax}}, 1'b1));
         queue_pixel(make_pixel({ChannelHalf, 16'h0001, ChannelMax, 16'h0000},
                                {ChannelMax, 16'h7FFF, 16'h0001, 16'h0000}, 1'b0));
         wait_drained();
      end
      write_mode(4'(pbc_pkg::MODE_DARKLIGHT + 1));
      queue_pixel(make_pixel({16'h1234, ChannelMax, 16'h0000, ChannelHalf},
                             {ChannelMax, 16'h0000, 16'h5678, 16'h0001}, 1'b1));
      wait_drained();
      write_mode(4'(ModeCodes - 1));
      queue_pixel(make_pixel({16'hA5A5, 16'h5A5A, ChannelMax, 16'h0000},
                             {16'h0000, ChannelMax, 16'h3C3C, ChannelHalf}, 1'b0));
      wait_drained();

      // Random: each idling phase walks through every mode code from a random start.
      for (int ph = 0; ph < 4; ph++) begin
         int start;
         send_idle_pct = phase_send[ph];
         stall_pct = phase_stall[ph];
         start = $urandom_range(ModeCodes - 1);
         for (int n = 0; n < ModeCodes; n++) begin
            write_mode(4'((start + n) % ModeCodes));
            for (int i = 0; i < PairsPerMode; i++) begin
               for (int c = 0; c < 4; c++) begin
                  base[c*16 +: 16] = pick_channel();
                  top[c*16 +: 16] = pick_channel();
               end
               queue_pixel(make_pixel(base, top, 1'($urandom)));
            end
            wait_drained();
         end
      end

      send_idle_pct = 0;
      stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
